// ===== src/seqal_pkg.sv =====
// Package for the three-stream sequence aligner: sizes, codes, types and
// address helpers shared by the control, memory and top-level files.
// No dependencies.
package seqal_pkg;

	localparam int NUM_CATEGORIES = 16;
	localparam int QUEUE_DEPTH    = 16;

	localparam int OP_W    = 2;
	localparam int CAT_W   = 4;
	localparam int SEQ_W   = 32;

	localparam int NUM_QUEUES  = 3 * NUM_CATEGORIES;
	localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QNUM_W      = $clog2(NUM_QUEUES);
	localparam int SADDR_W     = $clog2(STORE_DEPTH);

	// source codes
	localparam logic [OP_W-1:0] OP_CALC_A = 2'd0;
	localparam logic [OP_W-1:0] OP_CALC_B = 2'd1;
	localparam logic [OP_W-1:0] OP_REF    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PTR,
		ST_PUSH,
		ST_HEAD,
		ST_LOOP,
		ST_POP,
		ST_POPW,
		ST_MATCH,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [QIDX_W-1:0] head;
		logic [FILL_W-1:0] fill;
	} qptr_t;

	typedef struct packed {
		logic              we;
		logic [QNUM_W-1:0] addr;
		qptr_t             wdata;
	} ptr_req_t;

	typedef struct packed {
		logic               we;
		logic [SADDR_W-1:0] addr;
		logic [SEQ_W-1:0]   wdata;
	} store_req_t;

	typedef struct packed {
		logic             matched;
		logic [CAT_W-1:0] category;
		logic [SEQ_W-1:0] seq;
		logic             dropped;
	} result_t;

	function automatic logic [QNUM_W-1:0] qnum(input logic [1:0] slot,
			input logic [CAT_W-1:0] cat);
		int n;
		n = int'(slot) * NUM_CATEGORIES + int'(cat);
		return QNUM_W'(n);
	endfunction

	function automatic logic [SADDR_W-1:0] store_addr(input logic [QNUM_W-1:0] q,
			input logic [QIDX_W-1:0] idx);
		int a;
		a = int'(q) * QUEUE_DEPTH + int'(idx);
		return SADDR_W'(a);
	endfunction

	function automatic logic [QIDX_W-1:0] qidx_inc(input logic [QIDX_W-1:0] idx);
		logic [QIDX_W-1:0] r;
		if (idx == QIDX_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = idx + 1'b1;
		return r;
	endfunction

endpackage

// ===== src/three_stream_seq_aligner_top.sv =====
// Top level of the three-stream sequence aligner: sequencer, sequence memory,
// pointer memory and output register. Uses seqal_pkg and the seqal_* modules.
//
// Usage
//  - Input channel (in_valid/in_ready): one word names its source (op: first
//    calc, second calc, reference), its category and a 32-bit sequence number,
//    which is appended to that source's queue for the category.
//  - Output channel (out_valid/out_ready): exactly one result word per input
//    word. matched with matched_category/matched_seq reports a complete set
//    of three equal heads; dropped reports a push into a full queue. An
//    unknown source or category gives an all-zero result.
//  - Every word is processed on its own. An ignored word goes straight to
//    its result. A push loads the three queue pointers and, unless its queue
//    is full, appends the word, reads the heads, discards stale heads, pops
//    complete sets and writes the pointers back. The single port of the
//    sequence memory is reached once per head read.
//  - A finished result waits in the output register; the next word is taken
//    meanwhile, and its processing holds only at its final step while the
//    receiver stalls.
//  - Reset clears the pointer valid bits at once: every queue starts empty,
//    with no clearing pass. The sequence memory needs no reset.
module three_stream_seq_aligner_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [seqal_pkg::OP_W-1:0]  op,
	input  logic [seqal_pkg::CAT_W-1:0] category,
	input  logic [seqal_pkg::SEQ_W-1:0] seq_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        matched,
	output logic [seqal_pkg::CAT_W-1:0] matched_category,
	output logic [seqal_pkg::SEQ_W-1:0] matched_seq,
	output logic                        dropped
);
	import seqal_pkg::*;

	ptr_req_t         ptr_req;
	qptr_t            ptr_rdata;
	store_req_t       store_req;
	logic [SEQ_W-1:0] store_rdata;
	logic             res_valid;
	logic             res_ready;
	result_t          res;

	logic             out_valid_q;
	result_t          out_q;

	seqal_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.category    (category),
		.seq_id      (seq_id),
		.ptr_req     (ptr_req),
		.ptr_rdata   (ptr_rdata),
		.store_req   (store_req),
		.store_rdata (store_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// queue entries, one row per queue slot
	seqal_ram #(
		.WIDTH (SEQ_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_req.we),
		.addr  (store_req.addr),
		.wdata (store_req.wdata),
		.rdata (store_rdata)
	);

	seqal_ptr_mem u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ptr_req),
		.rdata  (ptr_rdata)
	);

	// hand the result over when the output register is free or being emptied
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign matched          = out_q.matched;
	assign matched_category = out_q.category;
	assign matched_seq      = out_q.seq;
	assign dropped          = out_q.dropped;

endmodule

// ===== src/seqal_ram.sv =====
// Generic single-port synchronous RAM, read-first, with registered read data.
// No dependencies.
module seqal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ===== src/seqal_ptr_mem.sv =====
// Queue pointer memory: head and fill of every queue, with per-entry valid
// bits so that an entry never written reads as empty. Uses seqal_pkg, seqal_ram.
module seqal_ptr_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  seqal_pkg::ptr_req_t req,
	output seqal_pkg::qptr_t    rdata
);
	import seqal_pkg::*;

	logic [NUM_QUEUES-1:0] valid_q;
	logic                  rvalid_s1;
	logic [$bits(qptr_t)-1:0] raw;

	seqal_ram #(
		.WIDTH ($bits(qptr_t)),
		.DEPTH (NUM_QUEUES)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.addr  (req.addr),
		.wdata (req.wdata),
		.rdata (raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (req.we) valid_q[req.addr] <= 1'b1;
			rvalid_s1 <= valid_q[req.addr];
		end
	end

	// an unwritten entry is an empty queue at index zero
	assign rdata = rvalid_s1 ? qptr_t'(raw) : '0;

endmodule

// ===== src/seqal_ctrl.sv =====
// Alignment sequencer: loads the three queue pointers of a category, appends
// the word unless its queue is full, discards stale heads, pops complete sets
// through the sequence memory and writes the pointers back. Uses seqal_pkg.
module seqal_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [seqal_pkg::OP_W-1:0]   op,
	input  logic [seqal_pkg::CAT_W-1:0]  category,
	input  logic [seqal_pkg::SEQ_W-1:0]  seq_id,
	output seqal_pkg::ptr_req_t          ptr_req,
	input  seqal_pkg::qptr_t             ptr_rdata,
	output seqal_pkg::store_req_t        store_req,
	input  logic [seqal_pkg::SEQ_W-1:0]  store_rdata,
	output logic                         res_valid,
	input  logic                         res_ready,
	output seqal_pkg::result_t           res
);
	import seqal_pkg::*;

	state_t state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] slot_q, slot_d;

	logic [OP_W-1:0]   op_q;
	logic [CAT_W-1:0]  cat_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [QIDX_W-1:0] head_q [3];
	logic [FILL_W-1:0] fill_q [3];
	logic [SEQ_W-1:0]  val_q [3];
	logic [SEQ_W-1:0]  big_q;
	logic              match_q;
	logic [SEQ_W-1:0]  mseq_q;
	logic              drop_q;

	logic [1:0]        cap;
	logic              all_ne;
	logic [SEQ_W-1:0]  m01, big_max;
	logic              pop_now;
	logic [QIDX_W-1:0] head_nxt;
	logic              set_done;
	logic              tgt_full;
	logic [QIDX_W:0]   pos_sum;
	logic [QIDX_W-1:0] push_pos;

	assign cap      = cnt_q - 2'd1;
	assign all_ne   = (fill_q[0] != '0) && (fill_q[1] != '0) && (fill_q[2] != '0);
	assign m01      = (val_q[1] > val_q[0]) ? val_q[1] : val_q[0];
	assign big_max  = (val_q[2] > m01) ? val_q[2] : m01;
	assign pop_now  = (fill_q[slot_q] != '0) && (val_q[slot_q] < big_q);
	assign head_nxt = qidx_inc(head_q[slot_q]);
	assign set_done = all_ne && (val_q[0] == big_q) && (val_q[1] == big_q) &&
		(val_q[2] == big_q);
	assign tgt_full = (fill_q[op_q] == FILL_W'(QUEUE_DEPTH));
	assign pos_sum  = (QIDX_W+1)'(head_q[op_q]) + (QIDX_W+1)'(fill_q[op_q]);
	assign push_pos = (pos_sum >= (QIDX_W+1)'(QUEUE_DEPTH)) ?
		QIDX_W'(pos_sum - (QIDX_W+1)'(QUEUE_DEPTH)) : QIDX_W'(pos_sum);

	assign res.matched  = match_q;
	assign res.category = match_q ? cat_q : '0;
	assign res.seq      = mseq_q;
	assign res.dropped  = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		slot_d    = slot_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ptr_req   = '0;
		store_req = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cnt_d = '0;
					if ((op > OP_REF) || (int'(category) >= NUM_CATEGORIES)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_PTR;
					end
				end
			end
			ST_PTR: begin
				if (cnt_q != 2'd3) ptr_req.addr = qnum(cnt_q, cat_q);
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (tgt_full) begin
					state_d = ST_DONE;
				end else begin
					store_req.we    = 1'b1;
					store_req.addr  = store_addr(qnum(op_q, cat_q), push_pos);
					store_req.wdata = seq_q;
					cnt_d           = '0;
					state_d         = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (cnt_q != 2'd3) store_req.addr = store_addr(qnum(cnt_q, cat_q), head_q[cnt_q]);
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (all_ne) begin
					slot_d  = '0;
					state_d = ST_POP;
				end else begin
					cnt_d   = '0;
					state_d = ST_WB;
				end
			end
			ST_POP: begin
				if (pop_now) begin
					store_req.addr = store_addr(qnum(slot_q, cat_q), head_nxt);
					state_d        = ST_POPW;
				end else if (slot_q == 2'd2) begin
					state_d = ST_MATCH;
				end else begin
					slot_d = slot_q + 2'd1;
				end
			end
			ST_POPW: begin
				state_d = ST_POP;
			end
			ST_MATCH: begin
				if (set_done) begin
					cnt_d   = '0;
					state_d = ST_HEAD;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_WB: begin
				ptr_req.we         = 1'b1;
				ptr_req.addr       = qnum(cnt_q, cat_q);
				ptr_req.wdata.head = head_q[cnt_q];
				ptr_req.wdata.fill = fill_q[cnt_q];
				cnt_d              = cnt_q + 2'd1;
				if (cnt_q == 2'd2) state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working copies of the three queues of the category
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q    <= op;
					cat_q   <= category;
					seq_q   <= seq_id;
					match_q <= 1'b0;
					mseq_q  <= '0;
					drop_q  <= 1'b0;
				end
			end
			ST_PTR: begin
				if (cnt_q != 2'd0) begin
					head_q[cap] <= ptr_rdata.head;
					fill_q[cap] <= ptr_rdata.fill;
				end
			end
			ST_PUSH: begin
				if (tgt_full) drop_q <= 1'b1;
				else fill_q[op_q] <= fill_q[op_q] + 1'b1;
			end
			ST_HEAD: begin
				if (cnt_q != 2'd0) val_q[cap] <= store_rdata;
			end
			ST_LOOP: begin
				big_q <= big_max;
			end
			ST_POP: begin
				if (pop_now) begin
					head_q[slot_q] <= head_nxt;
					fill_q[slot_q] <= fill_q[slot_q] - 1'b1;
				end
			end
			ST_POPW: begin
				val_q[slot_q] <= store_rdata;
			end
			ST_MATCH: begin
				if (set_done) begin
					match_q <= 1'b1;
					mseq_q  <= big_q;
					for (int i = 0; i < 3; i++) begin
						head_q[i] <= qidx_inc(head_q[i]);
						fill_q[i] <= fill_q[i] - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== src/seqal_checker.sv =====
// Port-level checker for the sequence aligner, bound to the top level.
// Uses seqal_pkg for field widths.
module seqal_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [seqal_pkg::OP_W-1:0]  op,
	input logic [seqal_pkg::CAT_W-1:0] category,
	input logic [seqal_pkg::SEQ_W-1:0] seq_id,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        matched,
	input logic [seqal_pkg::CAT_W-1:0] matched_category,
	input logic [seqal_pkg::SEQ_W-1:0] matched_seq,
	input logic                        dropped
);
	import seqal_pkg::*;

	// stalled result keeps matched, matched_seq and dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched) &&
		$stable(matched_seq) && $stable(dropped))
		else $error("result word changed while stalled");

	// a word is worked on alone
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in progress");

	a_match_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && dropped))
		else $error("result both matched and dropped");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> matched_seq == '0 && matched_category == '0)
		else $error("set fields non-zero without a match");

endmodule

bind three_stream_seq_aligner_top seqal_checker u_seqal_checker (.*);

// ===== test/tb_three_stream_seq_aligner_top.sv =====
// Self-checking testbench for three_stream_seq_aligner_top: random and directed
// words from the three sources, checked against a predictor of the aligner.
// Depends on seqal_pkg and the aligner RTL only.
`timescale 1ns / 100ps

module tb_three_stream_seq_aligner_top;
	import seqal_pkg::*;

	// the fourth source code names no source: the block ignores such words
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [OP_W-1:0]  src;
		logic [CAT_W-1:0] cat;
		logic [SEQ_W-1:0] seq;
	} msg_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = '0;
	logic [CAT_W-1:0]    category = '0;
	logic [SEQ_W-1:0]    seq_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                matched;
	logic [CAT_W-1:0]    matched_category;
	logic [SEQ_W-1:0]    matched_seq;
	logic                dropped;

	// words still to be offered, and results the predictor says are due
	msg_t    msgs_to_send [$];
	result_t predicted_outcomes [$];

	// predictor copy of every source queue of every category
	logic [SEQ_W-1:0] seq_mem [3][NUM_CATEGORIES][QUEUE_DEPTH];
	int unsigned      rd_ptr [3][NUM_CATEGORIES] = '{default: 0};
	int unsigned      occupancy [3][NUM_CATEGORIES] = '{default: 0};

	// running sequence number per category for the well-formed sets
	logic [SEQ_W-1:0] next_seq [NUM_CATEGORIES];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_taken = 0;
	int results_checked = 0;
	int sets_seen = 0;
	int drops_seen = 0;
	int mismatches = 0;

	// long receiver hold-off: armed once from the sequence, counted down here
	logic hold_armed = 1'b0;
	logic hold_served;
	int   hold_left;

	three_stream_seq_aligner_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.category         (category),
		.seq_id           (seq_id),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.matched_category (matched_category),
		.matched_seq      (matched_seq),
		.dropped          (dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [SEQ_W-1:0] head_of(input int s, input logic [CAT_W-1:0] cat);
		return seq_mem[s][cat][rd_ptr[s][cat]];
	endfunction

	function automatic logic all_busy(input logic [CAT_W-1:0] cat);
		return occupancy[0][cat] != 0 && occupancy[1][cat] != 0 && occupancy[2][cat] != 0;
	endfunction

	task automatic drop_head(input int s, input logic [CAT_W-1:0] cat);
		rd_ptr[s][cat] = (rd_ptr[s][cat] + 1) % QUEUE_DEPTH;
		occupancy[s][cat]--;
	endtask

	// Append one word to its source queue, then align the category: discard
	// heads below the largest head, and pop a set once all three heads agree.
	task automatic push_and_align(input logic [OP_W-1:0] src, input logic [CAT_W-1:0] cat,
			input logic [SEQ_W-1:0] seq, output result_t res);
		int unsigned      slot;
		logic [SEQ_W-1:0] big;
		res = '0;
		if (src > OP_REF || int'(cat) >= NUM_CATEGORIES)
			return;
		if (occupancy[src][cat] >= QUEUE_DEPTH) begin
			res.dropped = 1'b1;
			return;
		end
		slot = (rd_ptr[src][cat] + occupancy[src][cat]) % QUEUE_DEPTH;
		seq_mem[src][cat][slot] = seq;
		occupancy[src][cat]++;
		while (all_busy(cat)) begin
			big = head_of(0, cat);
			for (int s = 1; s < 3; s++)
				if (head_of(s, cat) > big)
					big = head_of(s, cat);
			for (int s = 0; s < 3; s++)
				while (occupancy[s][cat] != 0 && head_of(s, cat) < big)
					drop_head(s, cat);
			if (all_busy(cat) && head_of(0, cat) == big && head_of(1, cat) == big &&
					head_of(2, cat) == big) begin
				res.matched  = 1'b1;
				res.category = cat;
				res.seq      = big;
				for (int s = 0; s < 3; s++)
					drop_head(s, cat);
			end
		end
	endtask

	// ------------------------------------------------------------------ driver

	// Offer the next pending word unless the sender idles this cycle; hold
	// valid and payload steady until the word is taken. Predict at the handshake.
	always @(posedge clk or negedge arst_n) begin : word_driver
		result_t outcome;
		msg_t    nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= '0;
			category <= '0;
			seq_id   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				push_and_align(op, category, seq_id, outcome);
				predicted_outcomes.insert(predicted_outcomes.size(), outcome);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (msgs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = msgs_to_send[0];
					msgs_to_send.delete(0);
					in_valid <= 1'b1;
					op       <= nxt.src;
					category <= nxt.cat;
					seq_id   <= nxt.seq;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------ hold-off

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left   <= 0;
			hold_served <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_served) begin
			hold_left   <= HOLD_CYCLES;
			hold_served <= 1'b1;
		end
	end

	// ----------------------------------------------------------------- monitor

	task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
			input logic [SEQ_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Take a result when both sides agree and compare it with the oldest
	// prediction; stall at random, and throughout the hold-off.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (matched === 1'b1)
					sets_seen++;
				if (dropped === 1'b1)
					drops_seen++;
				if (predicted_outcomes.size() == 0) begin
					$display("%0t ns: result with no word outstanding: expected none, got %b %0h %0h %b",
						$time, matched, matched_category, matched_seq, dropped);
					mismatches++;
				end else begin
					want = predicted_outcomes[0];
					predicted_outcomes.delete(0);
					check_field("matched", want.matched, matched);
					check_field("matched_category", want.category, matched_category);
					check_field("matched_seq", want.seq, matched_seq);
					check_field("dropped", want.dropped, dropped);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	// append one word to the pending list
	task automatic enqueue_msg(input logic [OP_W-1:0] src, input logic [CAT_W-1:0] cat,
			input logic [SEQ_W-1:0] seq);
		msg_t m;
		m.src = src;
		m.cat = cat;
		m.seq = seq;
		msgs_to_send.insert(msgs_to_send.size(), m);
	endtask

	// Mostly well-formed sets: one category, the next sequence number, the
	// three sources in a random order with the odd source left out. The rest
	// is noise: any source code, numbers near the running one or anywhere.
	task automatic add_random_words(input int target);
		int               made;
		int               first;
		int               dir;
		int               order [3];
		logic [OP_W-1:0]  src;
		logic [CAT_W-1:0] cat;
		logic [SEQ_W-1:0] seq;
		made = 0;
		while (made < target) begin
			cat = CAT_W'($urandom_range(NUM_CATEGORIES - 1));
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(99) < 3)
					next_seq[cat] = $urandom;
				next_seq[cat] = next_seq[cat] + SEQ_W'($urandom_range(1, 4));
				first = $urandom_range(2);
				dir = $urandom_range(1);
				order[0] = first;
				order[1] = (first + 1 + dir) % 3;
				order[2] = (first + 2 - dir) % 3;
				for (int k = 0; k < 3; k++)
					if ($urandom_range(99) < 90) begin
						enqueue_msg(OP_W'(order[k]), cat, next_seq[cat]);
						made++;
					end
			end else begin
				src = OP_W'($urandom_range(3));
				if ($urandom_range(99) < 10)
					seq = $urandom;
				else
					seq = next_seq[cat] + SEQ_W'($urandom_range(6)) - SEQ_W'(3);
				enqueue_msg(src, cat, seq);
				if (src != OP_UNKNOWN)
					made++;
			end
		end
	endtask

	// sample at the falling edge so nothing races the clocked processes
	task automatic wait_drained();
		while (msgs_to_send.size() != 0 || in_valid || predicted_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin : run_sequence
		for (int c = 0; c < NUM_CATEGORIES; c++)
			next_seq[c] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: ignored source at the top of every field, a set at zero in
		// the lowest category, then fill the reference queue of the top
		// category so the next push is dropped, and complete a set at the
		// largest number, which discards all the stale reference heads.
		enqueue_msg(OP_UNKNOWN, 4'hf, 32'hffff_ffff);
		enqueue_msg(OP_CALC_A, 4'h0, 32'h0000_0000);
		enqueue_msg(OP_CALC_B, 4'h0, 32'h0000_0000);
		enqueue_msg(OP_REF, 4'h0, 32'h0000_0000);
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			enqueue_msg(OP_REF, 4'hf, 32'hffff_fff0 + SEQ_W'(i));
		enqueue_msg(OP_CALC_B, 4'hf, 32'hffff_ffff);
		enqueue_msg(OP_CALC_A, 4'hf, 32'hffff_ffff);
		wait_drained();

		// Full speed, with one long hold-off on the result side so the block
		// backs up and drops in_ready while words keep coming.
		hold_armed = 1'b1;
		add_random_words(260);
		wait_drained();

		send_idle_pct = 53;
		add_random_words(260);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 53;
		add_random_words(260);
		wait_drained();

		send_idle_pct = 24;
		recv_stall_pct = 24;
		add_random_words(270);
		wait_drained();

		// let any stray result show itself before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d words under four idling modes plus a %0d-cycle receiver hold-off.",
			words_taken, HOLD_CYCLES);
		$display("Checked %0d results: %0d complete sets, %0d pushes into a full queue.",
			results_checked, sets_seen, drops_seen);
		if (mismatches == 0 && predicted_outcomes.size() == 0)
			$display("three_stream_seq_aligner_top: match");
		else
			$display("three_stream_seq_aligner_top: mismatch");
		$finish;
	end

	// give up if the block stops moving
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding",
			cycles, predicted_outcomes.size());
		$display("three_stream_seq_aligner_top: mismatch");
		$finish;
	end

endmodule

// ===== three_stream_seq_aligner_top.f =====
src/seqal_pkg.sv
src/seqal_ram.sv
src/seqal_ptr_mem.sv
src/seqal_ctrl.sv
src/three_stream_seq_aligner_top.sv
src/seqal_checker.sv
test/tb_three_stream_seq_aligner_top.sv
